### hw/rtl/aprb_pkg.sv
package aprb_pkg;

   // Instruction class match patterns
   localparam logic [31:0] ADR_MASK    = 32'h1f00_0000;
   localparam logic [31:0] ADR_MATCH   = 32'h1000_0000;
   localparam logic [31:0] BCOND_MASK  = 32'hff00_0010;
   localparam logic [31:0] BCOND_MATCH = 32'h5400_0000;
   localparam logic [31:0] BREG_MASK   = 32'hf700_0000;
   localparam logic [31:0] BREG_MATCH  = 32'hd600_0000;
   localparam logic [31:0] BREG_RN_CLR = 32'hffff_fc1f;
   localparam logic [31:0] BR_MATCH    = 32'hd61f_0000;
   localparam logic [31:0] BLR_MATCH   = 32'hd63f_0000;
   localparam logic [31:0] RET_MATCH   = 32'hd65f_0000;
   localparam logic [31:0] BIMM_MASK   = 32'h7c00_0000;
   localparam logic [31:0] BIMM_MATCH  = 32'h1400_0000;
   localparam logic [31:0] CMPB_MASK   = 32'h7e00_0000;
   localparam logic [31:0] CBZ_MATCH   = 32'h3400_0000;
   localparam logic [31:0] TBZ_MATCH   = 32'h3600_0000;
   localparam logic [31:0] LDRL_MASK   = 32'h3b00_0000;
   localparam logic [31:0] LDRL_MATCH  = 32'h1800_0000;

   localparam logic [4:0]  LINK_REG    = 5'd30;
   localparam logic [1:0]  OPC_PRFM    = 2'd3;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_ADR,
      CLS_BCOND,
      CLS_BREG,
      CLS_BIMM,
      CLS_CBZ,
      CLS_TBZ,
      CLS_LDRL
   } op_class_type;

   // Condition groups selected by cond[3:1]
   typedef enum logic [2:0] {
      CG_EQ = 3'd0,
      CG_CS = 3'd1,
      CG_MI = 3'd2,
      CG_VS = 3'd3,
      CG_HI = 3'd4,
      CG_GE = 3'd5,
      CG_GT = 3'd6,
      CG_AL = 3'd7
   } cond_group_type;

   localparam logic [3:0] COND_NV = 4'hf;

   typedef enum logic [1:0] {
      LOAD_WORD_ZX = 2'd0,
      LOAD_DOUBLE  = 2'd1,
      LOAD_WORD_SX = 2'd2,
      LOAD_QUAD    = 2'd3
   } load_kind_type;

   typedef enum logic [1:0] {
      LOPC_WORD   = 2'd0,
      LOPC_DOUBLE = 2'd1,
      LOPC_WIDE   = 2'd2
   } load_opc_type;

   typedef struct packed {
      logic [31:0] opcode;
      logic [63:0] pc;
      logic [3:0]  flags_nzcv;
      logic [63:0] operand_value;
      logic        execute;
   } req_payload_type;

   typedef struct packed {
      logic        emulated;
      logic        redirected;
      logic [63:0] next_pc;
      logic        gpr_write;
      logic [4:0]  dest_index;
      logic [63:0] write_value;
      logic        load_request;
      logic [63:0] load_address;
      logic [1:0]  load_kind;
      logic        load_to_vector;
   } rsp_payload_type;

endpackage

### hw/rtl/aprb_if.sv
interface aprb_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] opcode;
   logic [63:0] pc;
   logic [3:0]  flags_nzcv;
   logic [63:0] operand_value;
   logic        execute;

   modport source (output valid, opcode, pc, flags_nzcv, operand_value, execute,
                   input ready);
   modport sink   (input valid, opcode, pc, flags_nzcv, operand_value, execute,
                   output ready);
endinterface

interface aprb_rsp_if;
   logic        valid;
   logic        ready;
   logic        emulated;
   logic        redirected;
   logic [63:0] next_pc;
   logic        gpr_write;
   logic [4:0]  dest_index;
   logic [63:0] write_value;
   logic        load_request;
   logic [63:0] load_address;
   logic [1:0]  load_kind;
   logic        load_to_vector;

   modport source (output valid, emulated, redirected, next_pc, gpr_write, dest_index,
                   write_value, load_request, load_address, load_kind, load_to_vector,
                   input ready);
   modport sink   (input valid, emulated, redirected, next_pc, gpr_write, dest_index,
                   write_value, load_request, load_address, load_kind, load_to_vector,
                   output ready);
endinterface

### hw/rtl/aprb_exec.sv
module aprb_exec (
   input  aprb_pkg::req_payload_type req,
   output aprb_pkg::rsp_payload_type rsp
);
   import aprb_pkg::*;

   logic [31:0]    op;
   logic [31:0]    breg_key;
   op_class_type   cls;
   logic [63:0]    off_adr;
   logic [63:0]    off_adrp;
   logic [63:0]    off_imm19;
   logic [63:0]    off_imm26;
   logic [63:0]    off_imm14;
   logic [63:0]    add_base;
   logic [63:0]    add_off;
   logic [63:0]    add_sum;
   logic [63:0]    pc_plus4;
   logic [3:0]     cond;
   logic           flag_n, flag_z, flag_c, flag_v;
   logic           cond_base;
   logic           cond_ok;
   logic           cmp_zero;
   logic           test_bit;
   logic           taken;
   logic           ex;
   logic           link;

   assign op       = req.opcode;
   assign ex       = req.execute;
   assign breg_key = op & BREG_RN_CLR;

   // Classify in priority order; an outer match with a bad sub-field stops the search
   always_comb begin
      cls = CLS_NONE;
      if ((op & ADR_MASK) == ADR_MATCH) begin
         cls = CLS_ADR;
      end else if ((op & BCOND_MASK) == BCOND_MATCH) begin
         cls = CLS_BCOND;
      end else if ((op & BREG_MASK) == BREG_MATCH) begin
         if (breg_key == BR_MATCH || breg_key == BLR_MATCH || breg_key == RET_MATCH) begin
            cls = CLS_BREG;
         end
      end else if ((op & BIMM_MASK) == BIMM_MATCH) begin
         cls = CLS_BIMM;
      end else if ((op & CMPB_MASK) == CBZ_MATCH) begin
         cls = CLS_CBZ;
      end else if ((op & CMPB_MASK) == TBZ_MATCH) begin
         cls = CLS_TBZ;
      end else if ((op & LDRL_MASK) == LDRL_MATCH) begin
         if (op[31:30] != OPC_PRFM) begin
            cls = CLS_LDRL;
         end
      end
   end

   // Sign-extended immediates
   assign off_adr   = {{43{op[23]}}, op[23:5], op[30:29]};
   assign off_adrp  = {{31{op[23]}}, op[23:5], op[30:29], 12'h000};
   assign off_imm19 = {{43{op[23]}}, op[23:5], 2'b00};
   assign off_imm26 = {{36{op[25]}}, op[25:0], 2'b00};
   assign off_imm14 = {{48{op[18]}}, op[18:5], 2'b00};

   // Share one address adder across all PC-relative forms
   always_comb begin
      add_base = req.pc;
      add_off  = off_imm19;
      case (cls)
         CLS_ADR: begin
            if (op[31]) begin
               add_base = {req.pc[63:12], 12'h000};
               add_off  = off_adrp;
            end else begin
               add_off  = off_adr;
            end
         end
         CLS_BIMM: add_off = off_imm26;
         CLS_TBZ:  add_off = off_imm14;
         default:  add_off = off_imm19;
      endcase
   end

   assign add_sum  = add_base + add_off;
   assign pc_plus4 = req.pc + 64'd4;

   // Evaluate the branch condition
   assign cond   = op[3:0];
   assign flag_n = req.flags_nzcv[3];
   assign flag_z = req.flags_nzcv[2];
   assign flag_c = req.flags_nzcv[1];
   assign flag_v = req.flags_nzcv[0];

   always_comb begin
      case (cond_group_type'(cond[3:1]))
         CG_EQ:   cond_base = flag_z;
         CG_CS:   cond_base = flag_c;
         CG_MI:   cond_base = flag_n;
         CG_VS:   cond_base = flag_v;
         CG_HI:   cond_base = flag_c && !flag_z;
         CG_GE:   cond_base = (flag_n == flag_v);
         CG_GT:   cond_base = (flag_n == flag_v) && !flag_z;
         default: cond_base = 1'b1;
      endcase
   end

   assign cond_ok  = (cond[0] && cond != COND_NV) ? !cond_base : cond_base;
   assign cmp_zero = op[31] ? (req.operand_value == 64'd0)
                            : (req.operand_value[31:0] == 32'd0);
   assign test_bit = req.operand_value[{op[31], op[23:19]}];

   always_comb begin
      case (cls)
         CLS_BCOND: taken = cond_ok;
         CLS_BREG:  taken = 1'b1;
         CLS_BIMM:  taken = 1'b1;
         CLS_CBZ:   taken = cmp_zero ^ op[24];
         CLS_TBZ:   taken = (test_bit == op[24]);
         default:   taken = 1'b0;
      endcase
   end

   assign link = (cls == CLS_BREG && breg_key == BLR_MATCH) || (cls == CLS_BIMM && op[31]);

   // Assemble the result; fields that do not apply stay zero
   always_comb begin
      rsp                = '0;
      rsp.emulated       = (cls != CLS_NONE);
      rsp.redirected     = ex && taken;
      rsp.next_pc        = pc_plus4;
      if (ex && taken) begin
         rsp.next_pc = (cls == CLS_BREG) ? req.operand_value : add_sum;
      end
      if (ex && cls == CLS_ADR) begin
         rsp.gpr_write   = 1'b1;
         rsp.dest_index  = op[4:0];
         rsp.write_value = add_sum;
      end else if (ex && link) begin
         rsp.gpr_write   = 1'b1;
         rsp.dest_index  = LINK_REG;
         rsp.write_value = pc_plus4;
      end else if (ex && cls == CLS_LDRL) begin
         rsp.load_request   = 1'b1;
         rsp.dest_index     = op[4:0];
         rsp.load_address   = add_sum;
         rsp.load_to_vector = op[26];
         case (load_opc_type'(op[31:30]))
            LOPC_WORD:   rsp.load_kind = LOAD_WORD_ZX;
            LOPC_DOUBLE: rsp.load_kind = LOAD_DOUBLE;
            default:     rsp.load_kind = op[26] ? LOAD_QUAD : LOAD_WORD_SX;
         endcase
      end
   end

endmodule

### hw/rtl/aarch64_pc_relative_branch_unit_core.sv
// AArch64 PC-relative branch and address execute unit.
//
// Request channel (req_chan): one instruction word with its PC, NZCV flags,
// the value of the register it names and an execute flag. Response channel
// (rsp_chan): classification, next PC, direct register write and, for a
// literal load, the load address and kind. Both use valid/ready; a request
// moves when valid and ready are high at the same rising edge.
//
// A taken request enters the input register; its result moves into the
// result register, which drives rsp_chan.valid, once that register is free.
// The path is an input register, the decode/add logic (one shared 64-bit
// address adder plus the PC+4 incrementer), then the result register.
// Throughput is one request per cycle; the two registers form a pipeline that
// keeps accepting while a finished response waits, and fills both stages
// before req_chan.ready drops.
//
// Reset (synchronous, active high) empties both stages; no response is valid
// the cycle after reset. When the receiver holds rsp_chan.ready low the
// response and its payload hold steady.
module aarch64_pc_relative_branch_unit_core (
   input  logic       clock,
   input  logic       reset,
   aprb_req_if.sink   req_chan,
   aprb_rsp_if.source rsp_chan
);
   import aprb_pkg::*;

   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_data_ff;
   logic            s2_valid_ff, s2_valid_in;
   rsp_payload_type s2_data_ff;
   rsp_payload_type exec_rsp;
   logic            s1_free;
   logic            s2_free;

   // Stage is free when empty or when its content moves on this cycle
   assign s2_free = !s2_valid_ff || rsp_chan.ready;
   assign s1_free = !s1_valid_ff || s2_free;

   assign req_chan.ready = s1_free;

   assign s1_valid_in = s1_free ? req_chan.valid : s1_valid_ff;
   assign s2_valid_in = s2_free ? s1_valid_ff    : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (req_chan.valid && s1_free) begin
         s1_data_ff.opcode        <= req_chan.opcode;
         s1_data_ff.pc            <= req_chan.pc;
         s1_data_ff.flags_nzcv    <= req_chan.flags_nzcv;
         s1_data_ff.operand_value <= req_chan.operand_value;
         s1_data_ff.execute       <= req_chan.execute;
      end
   end

   aprb_exec u_exec (
      .req (s1_data_ff),
      .rsp (exec_rsp)
   );

   // Advance the result into the response register
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_free) begin
         s2_data_ff <= exec_rsp;
      end
   end

   assign rsp_chan.valid          = s2_valid_ff;
   assign rsp_chan.emulated       = s2_data_ff.emulated;
   assign rsp_chan.redirected     = s2_data_ff.redirected;
   assign rsp_chan.next_pc        = s2_data_ff.next_pc;
   assign rsp_chan.gpr_write      = s2_data_ff.gpr_write;
   assign rsp_chan.dest_index     = s2_data_ff.dest_index;
   assign rsp_chan.write_value    = s2_data_ff.write_value;
   assign rsp_chan.load_request   = s2_data_ff.load_request;
   assign rsp_chan.load_address   = s2_data_ff.load_address;
   assign rsp_chan.load_kind      = s2_data_ff.load_kind;
   assign rsp_chan.load_to_vector = s2_data_ff.load_to_vector;

endmodule

### hw/rtl/aprb_checker.sv
module aprb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_emulated,
   input logic        rsp_redirected,
   input logic        rsp_gpr_write,
   input logic        rsp_load_request,
   input logic [63:0] rsp_next_pc
);

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc))
      else $error("stalled response dropped or changed");

   // Drain the pipeline on reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Unhandled opcodes cause no effects
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_emulated |-> !rsp_redirected && !rsp_gpr_write && !rsp_load_request)
      else $error("effect reported for unhandled opcode");

   // A literal load neither branches nor writes a register directly
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_load_request |-> !rsp_redirected && !rsp_gpr_write)
      else $error("load request mixed with other effects");

endmodule

bind aarch64_pc_relative_branch_unit_core aprb_checker u_aprb_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_emulated     (rsp_chan.emulated),
   .rsp_redirected   (rsp_chan.redirected),
   .rsp_gpr_write    (rsp_chan.gpr_write),
   .rsp_load_request (rsp_chan.load_request),
   .rsp_next_pc      (rsp_chan.next_pc)
);

### bench/tb_top.sv
module tb_top;
   import aprb_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int DIRECTED_COUNT = 25;
   localparam int DRAIN_CYCLES = 4;
   localparam int RSP_HOLD_CYCLES = 48;

   typedef struct packed {
      req_payload_type req;
      logic            typed;
      rsp_payload_type want;
   } stim_row_type;

   // Directed requests; rows with typed set carry their response inline
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // classify only: ADR without execute
      '{'{32'h1000_0000, 64'h1000, 4'h0, 64'h0, 1'b0}, 1'b1,
        '{1'b1, 1'b0, 64'h1004, 1'b0, 5'd0, 64'h0, 1'b0, 64'h0, LOAD_WORD_ZX, 1'b0}},
      // unhandled all-zero and all-ones words, pc + 4 wraps on the second
      '{'{32'h0000_0000, 64'h0, 4'h0, 64'h0, 1'b1}, 1'b1,
        '{1'b0, 1'b0, 64'h4, 1'b0, 5'd0, 64'h0, 1'b0, 64'h0, LOAD_WORD_ZX, 1'b0}},
      '{'{32'hffff_ffff, 64'hffff_ffff_ffff_fffc, 4'hf, 64'hffff_ffff_ffff_ffff, 1'b1},
        1'b1, '{1'b0, 1'b0, 64'h0, 1'b0, 5'd0, 64'h0, 1'b0, 64'h0, LOAD_WORD_ZX, 1'b0}},
      // ADR largest positive offset to register 31, ADRP one page back
      '{'{32'h707f_ffff, 64'hffff_ffff_ffff_fffc, 4'h0, 64'h0, 1'b1}, 1'b0, '0},
      '{'{32'hf0ff_ffe5, 64'h1234_5678_9abc_def0, 4'h0, 64'h0, 1'b1}, 1'b0, '0},
      // B.EQ taken with zero offset
      '{'{32'h5400_0000, 64'h4000, 4'h4, 64'h0, 1'b1}, 1'b1,
        '{1'b1, 1'b1, 64'h4000, 1'b0, 5'd0, 64'h0, 1'b0, 64'h0, LOAD_WORD_ZX, 1'b0}},
      // B.NE not taken, B.NV always taken, B.GT largest offset
      '{'{32'h5400_0021, 64'h4000, 4'h4, 64'h0, 1'b1}, 1'b0, '0},
      '{'{32'h5480_000f, 64'h0, 4'hf, 64'h0, 1'b1}, 1'b0, '0},
      '{'{32'h547f_ffec, 64'h8000, 4'h0, 64'h0, 1'b1}, 1'b0, '0},
      // BR, BLR with link write, RET to zero
      '{'{32'hd61f_0020, 64'h2000, 4'h0, 64'hfedc_ba98_7654_3210, 1'b1}, 1'b1,
        '{1'b1, 1'b1, 64'hfedc_ba98_7654_3210, 1'b0, 5'd0, 64'h0, 1'b0, 64'h0,
          LOAD_WORD_ZX, 1'b0}},
      '{'{32'hd63f_03c0, 64'h2000, 4'h0, 64'hffff_ffff_ffff_ffff, 1'b1}, 1'b1,
        '{1'b1, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1, LINK_REG, 64'h2004, 1'b0, 64'h0,
          LOAD_WORD_ZX, 1'b0}},
      '{'{32'hd65f_03c0, 64'h2000, 4'h0, 64'h0, 1'b1}, 1'b1,
        '{1'b1, 1'b1, 64'h0, 1'b0, 5'd0, 64'h0, 1'b0, 64'h0, LOAD_WORD_ZX, 1'b0}},
      // other branch-register encoding: not handled
      '{'{32'hd69f_03e0, 64'h3000, 4'h0, 64'h1234, 1'b1}, 1'b1,
        '{1'b0, 1'b0, 64'h3004, 1'b0, 5'd0, 64'h0, 1'b0, 64'h0, LOAD_WORD_ZX, 1'b0}},
      // B most negative, BL largest positive with wrap
      '{'{32'h1600_0000, 64'h0, 4'h0, 64'h0, 1'b1}, 1'b0, '0},
      '{'{32'h95ff_ffff, 64'hffff_ffff_ffff_fff0, 4'h0, 64'h0, 1'b1}, 1'b0, '0},
      // CBZ on W view of a value with only upper bits set, CBNZ on zero
      '{'{32'h3400_0003, 64'h6000, 4'h0, 64'hffff_ffff_0000_0000, 1'b1}, 1'b0, '0},
      '{'{32'hb5ff_ffe3, 64'h6000, 4'h0, 64'h0, 1'b1}, 1'b0, '0},
      // TBNZ on bit 63, TBZ on bit 0 with largest offset
      '{'{32'hb7ff_ffe1, 64'h7000, 4'h0, 64'h8000_0000_0000_0000, 1'b1}, 1'b0, '0},
      '{'{32'h3603_ffe0, 64'h7000, 4'h0, 64'h1, 1'b1}, 1'b0, '0},
      // literal loads of every kind, scalar and vector
      '{'{32'h1800_0001, 64'h100, 4'h0, 64'h0, 1'b1}, 1'b0, '0},
      '{'{32'h5880_0002, 64'h100, 4'h0, 64'h0, 1'b1}, 1'b0, '0},
      '{'{32'h987f_ffe3, 64'hffff_ffff_ffff_ff00, 4'h0, 64'h0, 1'b1}, 1'b0, '0},
      '{'{32'h9c00_0004, 64'h100, 4'h0, 64'h0, 1'b1}, 1'b0, '0},
      '{'{32'h1c00_0005, 64'h100, 4'h0, 64'h0, 1'b1}, 1'b0, '0},
      // prefetch literal: not handled
      '{'{32'hd800_0000, 64'h5000, 4'h0, 64'h0, 1'b1}, 1'b1,
        '{1'b0, 1'b0, 64'h5004, 1'b0, 5'd0, 64'h0, 1'b0, 64'h0, LOAD_WORD_ZX, 1'b0}}
   };

   logic clock;
   logic reset;

   aprb_req_if req_chan ();
   aprb_rsp_if rsp_chan ();

   aarch64_pc_relative_branch_unit_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rsp_payload_type pending_results [$];
   int              mismatch_count = 0;
   bit              req_idle_on = 1'b1;
   bit              rsp_idle_on = 1'b1;
   int              rsp_hold_len = 0;

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Evaluate a condition code against NZCV
   function automatic logic cond_holds(logic [3:0] nzcv, logic [3:0] cond);
      logic hit;
      case (cond_group_type'(cond[3:1]))
         CG_EQ:   hit = nzcv[2];
         CG_CS:   hit = nzcv[1];
         CG_MI:   hit = nzcv[3];
         CG_VS:   hit = nzcv[0];
         CG_HI:   hit = nzcv[1] && !nzcv[2];
         CG_GE:   hit = (nzcv[3] == nzcv[0]);
         CG_GT:   hit = (nzcv[3] == nzcv[0]) && !nzcv[2];
         default: hit = 1'b1;
      endcase
      // odd codes invert, except NV which stays always true
      if (cond[0] && cond != COND_NV) hit = !hit;
      return hit;
   endfunction

   // Work out the response to one request
   function automatic rsp_payload_type predict_branch_outcome(req_payload_type r);
      rsp_payload_type o;
      logic [31:0]     op;
      logic [31:0]     breg_key;
      logic [63:0]     adr_imm;
      logic [63:0]     imm19_ofs;
      logic [63:0]     tested;
      logic [5:0]      bit_pos;
      o = '0;
      op = r.opcode;
      o.next_pc = r.pc + 64'd4;
      adr_imm = {{43{op[23]}}, op[23:5], op[30:29]};
      imm19_ofs = {{43{op[23]}}, op[23:5], 2'b00};
      breg_key = op & BREG_RN_CLR;
      if ((op & ADR_MASK) == ADR_MATCH) begin
         o.emulated = 1'b1;
         if (r.execute) begin
            o.gpr_write = 1'b1;
            o.dest_index = op[4:0];
            if (op[31]) o.write_value = (r.pc & ~64'hfff) + (adr_imm << 12);
            else o.write_value = r.pc + adr_imm;
         end
      end else if ((op & BCOND_MASK) == BCOND_MATCH) begin
         o.emulated = 1'b1;
         if (r.execute && cond_holds(r.flags_nzcv, op[3:0])) begin
            o.redirected = 1'b1;
            o.next_pc = r.pc + imm19_ofs;
         end
      end else if ((op & BREG_MASK) == BREG_MATCH) begin
         if (breg_key == BR_MATCH || breg_key == BLR_MATCH || breg_key == RET_MATCH) begin
            o.emulated = 1'b1;
            if (r.execute) begin
               o.redirected = 1'b1;
               o.next_pc = r.operand_value;
               if (breg_key == BLR_MATCH) begin
                  o.gpr_write = 1'b1;
                  o.dest_index = LINK_REG;
                  o.write_value = r.pc + 64'd4;
               end
            end
         end
      end else if ((op & BIMM_MASK) == BIMM_MATCH) begin
         o.emulated = 1'b1;
         if (r.execute) begin
            o.redirected = 1'b1;
            o.next_pc = r.pc + {{36{op[25]}}, op[25:0], 2'b00};
            if (op[31]) begin
               o.gpr_write = 1'b1;
               o.dest_index = LINK_REG;
               o.write_value = r.pc + 64'd4;
            end
         end
      end else if ((op & CMPB_MASK) == CBZ_MATCH) begin
         o.emulated = 1'b1;
         if (r.execute) begin
            tested = op[31] ? r.operand_value : {32'h0, r.operand_value[31:0]};
            if ((tested == 64'h0) == !op[24]) begin
               o.redirected = 1'b1;
               o.next_pc = r.pc + imm19_ofs;
            end
         end
      end else if ((op & CMPB_MASK) == TBZ_MATCH) begin
         o.emulated = 1'b1;
         if (r.execute) begin
            bit_pos = {op[31], op[23:19]};
            if (r.operand_value[bit_pos] == op[24]) begin
               o.redirected = 1'b1;
               o.next_pc = r.pc + {{48{op[18]}}, op[18:5], 2'b00};
            end
         end
      end else if ((op & LDRL_MASK) == LDRL_MATCH) begin
         if (op[31:30] != OPC_PRFM) begin
            o.emulated = 1'b1;
            if (r.execute) begin
               o.load_request = 1'b1;
               o.dest_index = op[4:0];
               o.load_address = r.pc + imm19_ofs;
               o.load_to_vector = op[26];
               case (load_opc_type'(op[31:30]))
                  LOPC_WORD:   o.load_kind = LOAD_WORD_ZX;
                  LOPC_DOUBLE: o.load_kind = LOAD_DOUBLE;
                  default:     o.load_kind = op[26] ? LOAD_QUAD : LOAD_WORD_SX;
               endcase
            end
         end
      end
      return o;
   endfunction

   // Build a random request, mostly from the handled classes
   function automatic req_payload_type random_request();
      req_payload_type r;
      logic [31:0]     noise;
      noise = $urandom;
      case ($urandom_range(0, 9))
         0: r.opcode = (noise & ~ADR_MASK) | ADR_MATCH;
         1: r.opcode = (noise & ~BCOND_MASK) | BCOND_MATCH;
         2: begin
            case ($urandom_range(0, 3))
               0: r.opcode = (noise & ~BREG_MASK) | BREG_MATCH;
               1: r.opcode = BR_MATCH | (noise & ~BREG_RN_CLR);
               2: r.opcode = BLR_MATCH | (noise & ~BREG_RN_CLR);
               default: r.opcode = RET_MATCH | (noise & ~BREG_RN_CLR);
            endcase
         end
         3, 4: r.opcode = (noise & ~BIMM_MASK) | BIMM_MATCH;
         5: r.opcode = (noise & ~CMPB_MASK) | CBZ_MATCH;
         6: r.opcode = (noise & ~CMPB_MASK) | TBZ_MATCH;
         7, 8: r.opcode = (noise & ~LDRL_MASK) | LDRL_MATCH;
         default: r.opcode = noise;
      endcase
      case ($urandom_range(0, 4))
         0: r.operand_value = 64'h0;
         1: r.operand_value = {$urandom, 32'h0};
         2: r.operand_value = 64'h1 << $urandom_range(0, 63);
         default: r.operand_value = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 5))
         0: r.pc = 64'hffff_ffff_ffff_f000 | 64'($urandom_range(0, 4095));
         1: r.pc = 64'($urandom_range(0, 4095));
         default: r.pc = {$urandom, $urandom};
      endcase
      r.flags_nzcv = 4'($urandom_range(0, 15));
      r.execute = ($urandom_range(0, 15) != 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Offer one request at the falling edge and hold it until accepted
   task automatic drive_request(req_payload_type r, logic typed, rsp_payload_type want);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.opcode = r.opcode;
      req_chan.pc = r.pc;
      req_chan.flags_nzcv = r.flags_nzcv;
      req_chan.operand_value = r.operand_value;
      req_chan.execute = r.execute;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_results.push_back(typed ? want : predict_branch_outcome(r));
      @(negedge clock);
   endtask

   // Stop offering and wait for every outstanding response
   task automatic drain_results();
      req_chan.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Response side: ready with random stall bursts and one long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len != 0) begin
            rsp_chan.ready = 1'b0;
            repeat (rsp_hold_len) @(negedge clock);
            rsp_hold_len = 0;
         end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      rsp_payload_type seen;
      rsp_payload_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = '{rsp_chan.emulated, rsp_chan.redirected, rsp_chan.next_pc,
                  rsp_chan.gpr_write, rsp_chan.dest_index, rsp_chan.write_value,
                  rsp_chan.load_request, rsp_chan.load_address, rsp_chan.load_kind,
                  rsp_chan.load_to_vector};
         if (pending_results.size() == 0) begin
            report_mismatch("response with nothing pending", seen.next_pc, 64'h0);
         end else begin
            want = pending_results.pop_front();
            if (seen.emulated !== want.emulated)
               report_mismatch("emulated", 64'(seen.emulated), 64'(want.emulated));
            if (seen.redirected !== want.redirected)
               report_mismatch("redirected", 64'(seen.redirected), 64'(want.redirected));
            if (seen.next_pc !== want.next_pc)
               report_mismatch("next_pc", seen.next_pc, want.next_pc);
            if (seen.gpr_write !== want.gpr_write)
               report_mismatch("gpr_write", 64'(seen.gpr_write), 64'(want.gpr_write));
            if (seen.dest_index !== want.dest_index)
               report_mismatch("dest_index", 64'(seen.dest_index), 64'(want.dest_index));
            if (seen.write_value !== want.write_value)
               report_mismatch("write_value", seen.write_value, want.write_value);
            if (seen.load_request !== want.load_request)
               report_mismatch("load_request", 64'(seen.load_request),
                               64'(want.load_request));
            if (seen.load_address !== want.load_address)
               report_mismatch("load_address", seen.load_address, want.load_address);
            if (seen.load_kind !== want.load_kind)
               report_mismatch("load_kind", 64'(seen.load_kind), 64'(want.load_kind));
            if (seen.load_to_vector !== want.load_to_vector)
               report_mismatch("load_to_vector", 64'(seen.load_to_vector),
                               64'(want.load_to_vector));
         end
      end
   end

   // Main sequence: reset, directed table, random requests, drain
   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.opcode = '0;
      req_chan.pc = '0;
      req_chan.flags_nzcv = '0;
      req_chan.operand_value = '0;
      req_chan.execute = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_ROWS[k])
         drive_request(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // hold off the response side while requests keep coming
         if (i == 400) begin
            req_idle_on = 1'b0;
            rsp_hold_len = RSP_HOLD_CYCLES;
         end
         if (i == 460) req_idle_on = 1'b1;
         // pause requests until the pipeline is empty
         if (i == 800) drain_results();
         // no idling on either side for the last part
         if (i == 1200) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         drive_request(random_request(), 1'b0, '0);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[aarch64_pc_relative_branch_unit_core] OK");
      else
         $display("[aarch64_pc_relative_branch_unit_core] ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("[aarch64_pc_relative_branch_unit_core] ERROR");
      $finish;
   end

endmodule

### files.f
hw/rtl/aprb_pkg.sv
hw/rtl/aprb_if.sv
hw/rtl/aprb_exec.sv
hw/rtl/aarch64_pc_relative_branch_unit_core.sv
hw/rtl/aprb_checker.sv
bench/tb_top.sv
